>>> hw/rtl/bbm_pkg.sv
// Shared types and constants for the beat/bar marker generator.
// No dependencies; imported by bbm_ctrl, bbm_datapath, the top level and the testbench.
package bbm_pkg;

    localparam int MAX_MARKERS_DEFAULT = 64;
    localparam int TICK_BITS_DEFAULT   = 32;

    localparam int TPQ_W = 15;
    localparam int LEN_W = 17;

    localparam logic [TPQ_W-1:0] TPQ_RESET = 15'd96;
    localparam logic [LEN_W-1:0] LEN_RESET = 17'd96;
    localparam logic [7:0]       BPB_RESET = 8'd4;

    // request type codes
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_EVENT = 2'd1;
    localparam logic [1:0] REQ_TSIG  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    typedef struct packed {
        logic load_item;  // latch request fields
        logic setup;      // apply start, pick catch-up target
        logic calc_pend;  // decide the cap flag for this run
        logic step;       // capture a marker, advance the grid
        logic set_last;   // resolve last-in-run for the captured marker
        logic finish;     // write owed flag, apply time signature
    } bbm_cmd_t;

    typedef struct packed {
        logic none;       // request code without meaning
        logic run;        // catch-up pass required
        logic hit;        // a beat boundary lies at or before the target
        logic full;       // marker cap reached for this request
    } bbm_status_t;

endpackage

>>> hw/rtl/bbm_ctrl.sv
// Sequencer for the beat/bar marker generator.
// Depends on bbm_pkg; drives bbm_datapath through bbm_cmd_t.
module bbm_ctrl import bbm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  bbm_status_t status,
    output bbm_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PEND,
        ST_TEST,
        ST_FLAG,
        ST_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;
    logic   m_valid_reg;
    logic   do_step;

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

    assign do_step = status.run && status.hit && !status.full;

    always_comb begin
        cmd           = '0;
        cmd.load_item = (state_reg == ST_IDLE) && s_valid && s_ready_reg;
        cmd.setup     = (state_reg == ST_SETUP);
        cmd.calc_pend = (state_reg == ST_PEND);
        cmd.step      = (state_reg == ST_TEST) && do_step;
        cmd.set_last  = (state_reg == ST_FLAG);
        cmd.finish    = (state_reg == ST_FINISH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        state_reg   <= ST_SETUP;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_SETUP: begin
                    if (status.none) begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end else begin
                        state_reg <= ST_PEND;
                    end
                end
                ST_PEND: begin
                    state_reg <= ST_TEST;
                end
                ST_TEST: begin
                    if (do_step) begin
                        state_reg <= ST_FLAG;
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FLAG: begin
                    state_reg   <= ST_WAIT;
                    m_valid_reg <= 1'b1;
                end
                ST_WAIT: begin
                    if (m_ready) begin
                        state_reg   <= ST_TEST;
                        m_valid_reg <= 1'b0;
                    end
                end
                ST_FINISH: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b1;
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b1;
                    m_valid_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/bbm_datapath.sv
// Beat grid registers, catch-up arithmetic and marker output register.
// Depends on bbm_pkg; sequenced by bbm_ctrl.
module bbm_datapath import bbm_pkg::*; #(
    parameter int MAX_MARKERS_PER_ITEM = MAX_MARKERS_DEFAULT,
    parameter int TICK_BITS            = TICK_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [TPQ_W-1:0]  cfg_wr_data,
    input  logic [1:0]        s_req_type,
    input  logic [31:0]       s_event_tick,
    input  logic [7:0]        s_sig_numerator,
    input  logic [2:0]        s_sig_denom_exponent,
    output logic [31:0]       m_marker_tick,
    output logic [31:0]       m_bar_number,
    output logic [7:0]        m_beat_in_bar,
    output logic [7:0]        m_beats_per_bar,
    output logic              m_last_in_run,
    output logic              m_markers_pending,
    input  bbm_cmd_t          cmd,
    output bbm_status_t       status
);

    localparam int CNT_W  = $clog2(MAX_MARKERS_PER_ITEM + 1);
    localparam int MUL_W  = $clog2(MAX_MARKERS_PER_ITEM + 2);
    localparam int SPAN_W = LEN_W + MUL_W;
    localparam int CMP_W  = (TICK_BITS > SPAN_W) ? TICK_BITS : SPAN_W;

    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_MARKERS_PER_ITEM);
    localparam logic [MUL_W-1:0] SPAN_MUL = MUL_W'(MAX_MARKERS_PER_ITEM + 1);

    // configuration
    logic [TPQ_W-1:0]     tpq_reg;

    // latched request
    logic [1:0]           type_reg;
    logic [TICK_BITS-1:0] tick_in_reg;
    logic [7:0]           numer_reg;
    logic [2:0]           expo_reg;

    // grid state
    logic [TICK_BITS-1:0] last_seen_reg;
    logic [TICK_BITS-1:0] nbs_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [7:0]           bpb_reg;
    logic [31:0]          bar_reg;
    logic [8:0]           beat_reg;
    logic                 owed_reg;

    // run control
    logic [TICK_BITS-1:0] target_reg;
    logic                 run_reg;
    logic [SPAN_W-1:0]    span_reg;
    logic                 pend_reg;
    logic [CNT_W-1:0]     count_reg;

    // marker output register
    logic [31:0]          out_tick_reg;
    logic [31:0]          out_bar_reg;
    logic [7:0]           out_beat_reg;
    logic [7:0]           out_bpb_reg;
    logic                 out_last_reg;
    logic                 out_pend_reg;

    logic [63:0]          tick_ext;
    logic [63:0]          len_ext;
    logic [63:0]          nbs_ext;
    logic [TICK_BITS-1:0] len_tb;
    logic [TICK_BITS-1:0] diff;
    logic                 tgt_ge;
    logic                 hit;
    logic [LEN_W-1:0]     len_tpq;
    logic [LEN_W-1:0]     len_shift;
    logic [LEN_W-1:0]     len_tsig;
    logic [LEN_W-1:0]     len_eff;
    logic                 owed_eff;
    logic                 is_start;
    logic [8:0]           beat_inc;

    assign tick_ext = {32'd0, s_event_tick};
    assign len_ext  = {{(64 - LEN_W){1'b0}}, len_reg};
    assign nbs_ext  = 64'(nbs_reg);
    assign len_tb   = len_ext[TICK_BITS-1:0];

    // boundary test: target at least one beat past the next beat start
    assign diff   = target_reg - nbs_reg;
    assign tgt_ge = (target_reg >= nbs_reg);
    assign hit    = tgt_ge && (CMP_W'(diff) >= CMP_W'(len_reg));

    assign len_tpq   = (tpq_reg == '0) ? LEN_W'(1) : LEN_W'(tpq_reg);
    assign len_shift = {tpq_reg, 2'b00} >> expo_reg;
    assign len_tsig  = (len_shift == '0) ? LEN_W'(1) : len_shift;

    assign is_start  = (type_reg == REQ_START);
    assign len_eff   = is_start ? len_tpq : len_reg;
    assign owed_eff  = is_start ? 1'b0 : owed_reg;
    assign beat_inc  = beat_reg + 9'd1;

    assign status.none = (type_reg == REQ_NONE);
    assign status.run  = run_reg;
    assign status.hit  = hit;
    assign status.full = (count_reg == CNT_MAX);

    assign m_marker_tick     = out_tick_reg;
    assign m_bar_number      = out_bar_reg;
    assign m_beat_in_bar     = out_beat_reg;
    assign m_beats_per_bar   = out_bpb_reg;
    assign m_last_in_run     = out_last_reg;
    assign m_markers_pending = out_pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpq_reg       <= TPQ_RESET;
            last_seen_reg <= '0;
            nbs_reg       <= '0;
            len_reg       <= LEN_RESET;
            bpb_reg       <= BPB_RESET;
            bar_reg       <= '0;
            beat_reg      <= '0;
            owed_reg      <= 1'b0;
            run_reg       <= 1'b0;
            count_reg     <= '0;
            type_reg      <= REQ_NONE;
        end else begin
            if (cfg_wr_en) begin
                tpq_reg <= cfg_wr_data;
            end

            if (cmd.load_item) begin
                type_reg    <= s_req_type;
                tick_in_reg <= tick_ext[TICK_BITS-1:0];
                numer_reg   <= s_sig_numerator;
                expo_reg    <= s_sig_denom_exponent;
            end

            if (cmd.setup && !status.none) begin
                if (is_start) begin
                    len_reg  <= len_tpq;
                    bpb_reg  <= BPB_RESET;
                    nbs_reg  <= '0;
                    beat_reg <= 9'd1;
                    bar_reg  <= 32'd1;
                    owed_reg <= 1'b0;
                end
                if (tick_in_reg > last_seen_reg) begin
                    last_seen_reg <= tick_in_reg;
                    target_reg    <= tick_in_reg;
                    run_reg       <= 1'b1;
                end else if (owed_eff) begin
                    target_reg <= last_seen_reg;
                    run_reg    <= 1'b1;
                end else begin
                    run_reg <= 1'b0;
                end
                // span of the cap plus one beat; the grid never wraps inside a run
                span_reg  <= SPAN_W'(len_eff) * SPAN_W'(SPAN_MUL);
                count_reg <= '0;
            end

            if (cmd.calc_pend) begin
                pend_reg <= tgt_ge && (CMP_W'(diff) >= CMP_W'(span_reg));
            end

            if (cmd.step) begin
                out_tick_reg <= nbs_ext[31:0];
                out_bar_reg  <= bar_reg;
                out_beat_reg <= beat_reg[7:0];
                out_bpb_reg  <= bpb_reg;
                out_pend_reg <= pend_reg;
                nbs_reg      <= nbs_reg + len_tb;
                count_reg    <= count_reg + CNT_W'(1);
                if (beat_inc > {1'b0, bpb_reg}) begin
                    beat_reg <= 9'd1;
                    bar_reg  <= bar_reg + 32'd1;
                end else begin
                    beat_reg <= beat_inc;
                end
            end

            if (cmd.set_last) begin
                out_last_reg <= status.full || !hit;
            end

            if (cmd.finish) begin
                if (run_reg) begin
                    owed_reg <= hit;
                end
                if (type_reg == REQ_TSIG) begin
                    bpb_reg <= numer_reg;
                    len_reg <= len_tsig;
                end
            end
        end
    end

endmodule

>>> hw/rtl/beat_bar_marker_generator_top.sv
// Top level of the beat/bar marker generator: sequencer plus datapath.
// Depends on bbm_pkg, bbm_ctrl and bbm_datapath.

// Beat/bar marker generator. Each request (start of song, event, or time
// signature) carries a song tick; when the tick is later than the last tick
// seen, the block emits one marker per beat boundary passed, each with its
// tick, bar number, beat in bar and beats per bar. A run emits at most
// MAX_MARKERS_PER_ITEM markers; markers still owed are flagged on every
// marker of a capped run (markers_pending) and emitted by later requests.
// A start request resets the grid to 4/4, bar 1, beat 1, beat length =
// ticks_per_quarter; a time signature request catches up at its own tick
// first, then takes the new numerator and beat length
// (ticks_per_quarter * 4) >> exponent, never below 1. The block handles
// one request at a time. s_ready is high only while idle. For each marker
// the block captures it, resolves its last-in-run flag and then presents
// it until m_ready is high; a request code of 3 is dropped after setup
// without a run. The single grid-advance path in the datapath captures a
// marker into the output register and steps the beat grid in the same
// cycle. ticks_per_quarter is written through cfg_wr_en/cfg_wr_data
// (resets to 96) and must only be changed while the block is idle.
module beat_bar_marker_generator_top import bbm_pkg::*; #(
    parameter int MAX_MARKERS_PER_ITEM = MAX_MARKERS_DEFAULT,
    parameter int TICK_BITS            = TICK_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration: ticks per quarter note
    input  logic              cfg_wr_en,
    input  logic [TPQ_W-1:0]  cfg_wr_data,
    // request channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_req_type,
    input  logic [31:0]       s_event_tick,
    input  logic [7:0]        s_sig_numerator,
    input  logic [2:0]        s_sig_denom_exponent,
    // marker channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_marker_tick,
    output logic [31:0]       m_bar_number,
    output logic [7:0]        m_beat_in_bar,
    output logic [7:0]        m_beats_per_bar,
    output logic              m_last_in_run,
    output logic              m_markers_pending
);

    bbm_cmd_t    cmd;
    bbm_status_t status;

    // sequencer: request handshake, run loop, marker handshake
    bbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // grid state, boundary compare, cap flag and marker register
    bbm_datapath #(
        .MAX_MARKERS_PER_ITEM (MAX_MARKERS_PER_ITEM),
        .TICK_BITS            (TICK_BITS)
    ) u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .s_req_type           (s_req_type),
        .s_event_tick         (s_event_tick),
        .s_sig_numerator      (s_sig_numerator),
        .s_sig_denom_exponent (s_sig_denom_exponent),
        .m_marker_tick        (m_marker_tick),
        .m_bar_number         (m_bar_number),
        .m_beat_in_bar        (m_beat_in_bar),
        .m_beats_per_bar      (m_beats_per_bar),
        .m_last_in_run        (m_last_in_run),
        .m_markers_pending    (m_markers_pending),
        .cmd                  (cmd),
        .status               (status)
    );

    // one request in flight: never ready for a new request while a marker waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request accepted while a marker is outstanding");

    // after the last marker of a run is taken, no marker follows at once
    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_in_run) |=> !m_valid)
        else $error("marker presented right after last marker of run");

    // a request with no meaning is dropped and the block is ready again
    a_none_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_req_type == REQ_NONE)) |=> !s_ready ##1 s_ready)
        else $error("meaningless request not dropped");

    // the grid steps only while a boundary is due and the cap is not reached
    a_step_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (status.run && status.hit && !status.full))
        else $error("grid stepped without a pending boundary");

endmodule

>>> tb/sv/bbm_marker_checker.sv
// Marker checker for the beat/bar marker generator: predicts markers per request and compares.
// Depends on bbm_pkg for request codes, widths and reset constants.
module bbm_marker_checker import bbm_pkg::*; #(
    parameter int MAX_MARKERS = MAX_MARKERS_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [TPQ_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [1:0]       s_req_type,
    input  logic [31:0]      s_event_tick,
    input  logic [7:0]       s_sig_numerator,
    input  logic [2:0]       s_sig_denom_exponent,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [31:0]      m_marker_tick,
    input  logic [31:0]      m_bar_number,
    input  logic [7:0]       m_beat_in_bar,
    input  logic [7:0]       m_beats_per_bar,
    input  logic             m_last_in_run,
    input  logic             m_markers_pending,
    output int               fail_count,
    output int               markers_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] tick;
        logic [31:0] bar;
        logic [7:0]  beat;
        logic [7:0]  bpb;
        logic        last;
        logic        pending;
    } marker_t;

    marker_t expected_markers[$];

    // predicted grid state
    logic [TPQ_W-1:0] tpq;
    logic [31:0]      last_tick;
    logic [31:0]      grid_start;
    logic [LEN_W-1:0] beat_len;
    logic [7:0]       bpb;
    logic [31:0]      bar_cnt;
    logic [8:0]       beat_cnt;
    logic             owed;

    initial fail_count = 0;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        return (v == '0) ? LEN_W'(1) : v;
    endfunction

    function automatic logic boundary_due(input logic [31:0] target);
        return (target >= grid_start) && ((target - grid_start) >= {15'd0, beat_len});
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count = fail_count + 1;
        if (fail_count <= 40)
            $display("[%0t] marker error on %s: got 0x%0h, want 0x%0h",
                     $time, field, got, want);
    endtask

    task automatic run_catch_up(input logic [31:0] target);
        marker_t run_q[$];
        marker_t mk;
        int      n;
        n = 0;
        while (n < MAX_MARKERS && boundary_due(target)) begin
            mk.tick    = grid_start;
            mk.bar     = bar_cnt;
            mk.beat    = beat_cnt[7:0];
            mk.bpb     = bpb;
            mk.last    = 1'b0;
            mk.pending = 1'b0;
            run_q.push_back(mk);
            n = n + 1;
            grid_start = grid_start + {15'd0, beat_len};
            beat_cnt   = beat_cnt + 9'd1;
            if (beat_cnt > {1'b0, bpb}) begin
                beat_cnt = 9'd1;
                bar_cnt  = bar_cnt + 32'd1;
            end
        end
        owed = boundary_due(target);
        // pending flag goes on every marker of a run cut off at the cap
        for (int k = 0; k < n; k++) begin
            mk         = run_q[k];
            mk.pending = owed;
            mk.last    = (k == n - 1);
            expected_markers.push_back(mk);
        end
    endtask

    task automatic follow_song(input logic [31:0] tick);
        if (tick > last_tick) begin
            last_tick = tick;
            run_catch_up(tick);
        end else if (owed) begin
            run_catch_up(last_tick);
        end
    endtask

    task automatic predict_request(input logic [1:0] kind, input logic [31:0] tick,
                                   input logic [7:0] numer, input logic [2:0] expo);
        case (kind)
            REQ_START: begin
                beat_len   = clamp_len({2'b00, tpq});
                bpb        = BPB_RESET;
                grid_start = '0;
                beat_cnt   = 9'd1;
                bar_cnt    = 32'd1;
                owed       = 1'b0;
                follow_song(tick);
            end
            REQ_EVENT: begin
                follow_song(tick);
            end
            REQ_TSIG: begin
                follow_song(tick);
                bpb      = numer;
                beat_len = clamp_len({tpq, 2'b00} >> expo);
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_marker();
        marker_t want;
        if (expected_markers.size() == 0) begin
            report_mismatch("unexpected marker tick", m_marker_tick, '0);
        end else begin
            want = expected_markers.pop_front();
            if (m_marker_tick !== want.tick)
                report_mismatch("marker_tick", m_marker_tick, want.tick);
            if (m_bar_number !== want.bar)
                report_mismatch("bar_number", m_bar_number, want.bar);
            if (m_beat_in_bar !== want.beat)
                report_mismatch("beat_in_bar", {24'd0, m_beat_in_bar}, {24'd0, want.beat});
            if (m_beats_per_bar !== want.bpb)
                report_mismatch("beats_per_bar", {24'd0, m_beats_per_bar}, {24'd0, want.bpb});
            if (m_last_in_run !== want.last)
                report_mismatch("last_in_run", {31'd0, m_last_in_run}, {31'd0, want.last});
            if (m_markers_pending !== want.pending)
                report_mismatch("markers_pending", {31'd0, m_markers_pending},
                                {31'd0, want.pending});
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            tpq        = TPQ_RESET;
            last_tick  = '0;
            grid_start = '0;
            beat_len   = LEN_RESET;
            bpb        = BPB_RESET;
            bar_cnt    = '0;
            beat_cnt   = '0;
            owed       = 1'b0;
            expected_markers.delete();
        end else begin
            if (cfg_wr_en)
                tpq = cfg_wr_data;
            if (m_valid && m_ready)
                check_marker();
            if (s_valid && s_ready)
                predict_request(s_req_type, s_event_tick, s_sig_numerator,
                                s_sig_denom_exponent);
        end
        markers_due <= expected_markers.size();
    end

endmodule

>>> tb/sv/tb.sv
// Top of the beat/bar marker generator testbench: clock, reset, request stimulus, verdict.
// Depends on bbm_pkg, beat_bar_marker_generator_top and bbm_marker_checker.
module tb import bbm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [TPQ_W-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    logic [1:0]       s_req_type;
    logic [31:0]      s_event_tick;
    logic [7:0]       s_sig_numerator;
    logic [2:0]       s_sig_denom_exponent;
    logic             m_valid;
    logic             m_ready;
    logic [31:0]      m_marker_tick;
    logic [31:0]      m_bar_number;
    logic [7:0]       m_beat_in_bar;
    logic [7:0]       m_beats_per_bar;
    logic             m_last_in_run;
    logic             m_markers_pending;

    int fail_count;
    int markers_due;

    // stimulus-side bookkeeping
    logic [TPQ_W-1:0] tpq_now;      // last ticks_per_quarter written
    logic [31:0]      song_tick;    // latest tick offered so far
    int unsigned      beat_guess;   // rough beat length, scales tick steps
    bit               steady;       // no idling on either side while set
    bit               hold_req;     // asks the marker sink for one long hold-off

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    beat_bar_marker_generator_top dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_req_type           (s_req_type),
        .s_event_tick         (s_event_tick),
        .s_sig_numerator      (s_sig_numerator),
        .s_sig_denom_exponent (s_sig_denom_exponent),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_marker_tick        (m_marker_tick),
        .m_bar_number         (m_bar_number),
        .m_beat_in_bar        (m_beat_in_bar),
        .m_beats_per_bar      (m_beats_per_bar),
        .m_last_in_run        (m_last_in_run),
        .m_markers_pending    (m_markers_pending)
    );

    bbm_marker_checker u_marker_check (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_req_type           (s_req_type),
        .s_event_tick         (s_event_tick),
        .s_sig_numerator      (s_sig_numerator),
        .s_sig_denom_exponent (s_sig_denom_exponent),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_marker_tick        (m_marker_tick),
        .m_bar_number         (m_bar_number),
        .m_beat_in_bar        (m_beat_in_bar),
        .m_beats_per_bar      (m_beats_per_bar),
        .m_last_in_run        (m_last_in_run),
        .m_markers_pending    (m_markers_pending),
        .fail_count           (fail_count),
        .markers_due          (markers_due)
    );

    // Marker sink. m_ready moves only on the falling edge. Normally it drops
    // at random, with odds of about 6 in 100; one long hold-off is counted here when
    // the stimulus asks for it, so the block backs up and s_ready stays low.
    initial begin : marker_sink
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = 400;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 6);
            end
        end
    end

    // Offer one request and hold it until accepted. Fields change only on
    // the falling edge; acceptance is seen at the rising edge. A random gap
    // may come first. Valid stays high between back-to-back requests.
    task automatic send_request(input logic [1:0] kind, input logic [31:0] tick,
                                input logic [7:0] numer, input logic [2:0] expo);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 6)
            gap = $urandom_range(1, 8);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid              <= 1'b1;
        s_req_type           <= kind;
        s_event_tick         <= tick;
        s_sig_numerator      <= numer;
        s_sig_denom_exponent <= expo;
        do @(posedge aclk); while (!s_ready);
        if (kind != REQ_NONE && tick > song_tick)
            song_tick = tick;
    endtask

    // Stop offering and wait for every predicted marker, then give the block
    // time to finish a request that produced nothing.
    task automatic drain_markers();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (markers_due != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
    endtask

    // ticks_per_quarter is only written with the block idle
    task automatic write_tpq(input logic [TPQ_W-1:0] value);
        drain_markers();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        tpq_now = value;
    endtask

    // A song: a start request, then mostly forward events and time
    // signatures with random content, plus some restarts, late (backward)
    // ticks and meaningless request codes as noise. Steps in tick are up to three
    // beats so most requests produce a handful of markers.
    task automatic play_random_song(input int requests, input int pause_at,
                                    input int hold_at, input int steady_for);
        int          sent;
        int          pick;
        logic [31:0] tick;
        logic [7:0]  numer;
        logic [2:0]  expo;
        int unsigned len;
        sent   = 0;
        steady = (steady_for > 0);
        send_request(REQ_START, song_tick, 8'($urandom), 3'($urandom));
        beat_guess = (tpq_now == 0) ? 1 : tpq_now;
        while (sent < requests) begin
            pick  = $urandom_range(99);
            numer = 8'($urandom);
            expo  = 3'($urandom);
            tick  = song_tick + $urandom_range(0, 3 * beat_guess);
            if (pick < 5) begin
                // meaningless code: ignored, not counted
                send_request(REQ_NONE, $urandom, numer, expo);
            end else begin
                if (pick < 10)
                    tick = (song_tick > 300) ? song_tick - $urandom_range(0, 300) : '0;
                if (pick < 15) begin
                    send_request(REQ_START, tick, numer, expo);
                    beat_guess = (tpq_now == 0) ? 1 : tpq_now;
                end else if (pick < 32) begin
                    send_request(REQ_TSIG, tick, numer, expo);
                    len = ({2'b00, tpq_now} * 4) >> expo;
                    beat_guess = (len == 0) ? 1 : len;
                end else begin
                    send_request(REQ_EVENT, tick, numer, expo);
                end
                sent = sent + 1;
                if (sent == steady_for)
                    steady = 1'b0;
                if (sent == hold_at)
                    hold_req = 1'b1;
                // sender waits out every marker once mid-song
                if (sent == pause_at)
                    drain_markers();
            end
        end
        steady = 1'b0;
    endtask

    // run limit
    initial begin
        #2_000_000;
        $display("FAIL beat_bar_marker_generator_top");
        $finish;
    end

    initial begin : stimulus
        aresetn              = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = '0;
        s_valid              = 1'b0;
        s_req_type           = REQ_EVENT;
        s_event_tick         = '0;
        s_sig_numerator      = '0;
        s_sig_denom_exponent = '0;
        tpq_now              = TPQ_RESET;
        song_tick            = '0;
        beat_guess           = 96;
        steady               = 1'b0;
        hold_req             = 1'b0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed ---
        // before any start: grid as reset leaves it (bar 0, beat 0)
        write_tpq(15'd96);
        send_request(REQ_EVENT, 32'd0, 8'd0, 3'd0);        // not later: nothing
        send_request(REQ_EVENT, 32'd200, 8'd0, 3'd0);      // two markers, bar 0
        send_request(REQ_NONE, 32'hFFFF_FFFF, 8'hFF, 3'd7); // ignored

        // zero ticks per quarter: beat length forced to 1, runs hit the cap
        write_tpq(15'd0);
        send_request(REQ_START, 32'd200, 8'd0, 3'd0);      // tick not later
        send_request(REQ_EVENT, 32'd270, 8'd0, 3'd0);      // capped, owed
        send_request(REQ_EVENT, 32'd100, 8'd0, 3'd0);      // older tick, owed goes on

        // largest ticks per quarter; zero numerator after an owed catch-up
        write_tpq(15'd32767);
        send_request(REQ_TSIG, 32'd270, 8'd0, 3'd7);
        send_request(REQ_EVENT, 32'd270, 8'd0, 3'd0);
        send_request(REQ_EVENT, 32'd5000, 8'd0, 3'd0);     // every beat a new bar

        // shift down to zero, clamped to 1, then owed markers use new length
        write_tpq(15'd31);
        send_request(REQ_TSIG, 32'd5000, 8'd4, 3'd7);
        send_request(REQ_EVENT, 32'd5010, 8'd0, 3'd0);
        send_request(REQ_TSIG, 32'd5010, 8'd3, 3'd0);
        send_request(REQ_EVENT, 32'd5400, 8'd0, 3'd0);
        send_request(REQ_START, 32'd5400, 8'd0, 3'd0);
        send_request(REQ_EVENT, 32'd5500, 8'd0, 3'd0);     // capped
        send_request(REQ_START, 32'd5500, 8'd0, 3'd0);     // drops owed markers
        send_request(REQ_EVENT, 32'd5600, 8'd0, 3'd0);     // capped again
        send_request(REQ_EVENT, 32'd5600, 8'd0, 3'd0);     // owed
        send_request(REQ_TSIG, 32'd5600, 8'd6, 3'd0);      // owed, then new length
        send_request(REQ_EVENT, 32'd5600, 8'd0, 3'd0);     // no longer owed: nothing

        // --- random songs ---
        write_tpq(15'd96);
        play_random_song(42, 25, 10, 0);
        write_tpq(15'($urandom_range(300, 3000)));
        play_random_song(42, 0, 0, 25);

        // --- high ticks: full-width song times and capped runs ---
        write_tpq(15'($urandom_range(1, 32767)));
        repeat (6)
            send_request(REQ_EVENT, $urandom, 8'($urandom), 3'($urandom));
        send_request(REQ_TSIG, 32'h8000_0000, 8'hFF, 3'd7);
        send_request(REQ_START, 32'h7FFF_FFFF, 8'hFF, 3'd7);
        send_request(REQ_EVENT, 32'hFFFF_FFFF, 8'hFF, 3'd7);

        drain_markers();
        if (fail_count == 0)
            $display("PASS beat_bar_marker_generator_top");
        else
            $display("FAIL beat_bar_marker_generator_top");
        $finish;
    end

endmodule
